/* hdl/aus_pkg.sv */
`timescale 1ns / 1ps
`default_nettype none
package aus_pkg;

   // default geometry
   localparam int ANGLE_BITS_DEF = 16;
   localparam int ACC_BITS_DEF   = 32;

   // field widths on the ports
   localparam int ANGLE_W       = 16;
   localparam int ANGLE_TOTAL_W = 32;
   localparam int SPEED_W       = 32;
   localparam int RSP_DATA_W    = ANGLE_TOTAL_W + SPEED_W;

   // control registers
   localparam int ALPHA_W     = 17;
   localparam int RATE_W      = 16;
   localparam int CSR_DATA_W  = ALPHA_W;
   localparam int CSR_INDEX_W = 1;

   localparam logic [CSR_INDEX_W-1:0] CSR_FILTER_ALPHA = 1'b0;
   localparam logic [CSR_INDEX_W-1:0] CSR_SAMPLE_RATE  = 1'b1;

   localparam logic [ALPHA_W-1:0] ALPHA_RESET = '0;
   localparam logic [RATE_W-1:0]  RATE_RESET  = 16'd20000;

   // Q16 unity weight
   localparam int                 FRAC_BITS = 16;
   localparam logic [ALPHA_W-1:0] ALPHA_ONE = 17'h10000;

   localparam int S32_MAX = 2147483647;
   localparam int S32_MIN = -2147483647 - 1;

   // default shift-add datapath
   localparam int MAC_W_DEF = 2 * SPEED_W;

endpackage
`default_nettype wire

/* hdl/aus_serial_mac.sv */
`timescale 1ns / 1ps
`default_nettype none
module aus_serial_mac #(
   parameter int WIDTH     = aus_pkg::MAC_W_DEF,
   parameter int MULT_BITS = aus_pkg::ALPHA_W
) (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire logic                 start,
   input  wire logic [WIDTH-1:0]     mcand,
   input  wire logic [MULT_BITS-1:0] mplier,
   input  wire logic [WIDTH-1:0]     init,
   output logic                      busy,
   output logic                      done,
   output logic [WIDTH-1:0]          result
);

   localparam int CNT_W = $clog2(MULT_BITS + 1);

   logic                 busy_ff, busy_in;
   logic                 done_ff, done_in;
   logic [CNT_W-1:0]     count_ff, count_in;
   logic [WIDTH-1:0]     mcand_ff, mcand_in;
   logic [MULT_BITS-1:0] mplier_ff, mplier_in;
   logic [WIDTH-1:0]     acc_ff, acc_in;

   // one multiplier bit per cycle, lowest bit first
   always_comb begin
      busy_in   = busy_ff;
      done_in   = 1'b0;
      count_in  = count_ff;
      mcand_in  = mcand_ff;
      mplier_in = mplier_ff;
      acc_in    = acc_ff;
      if (start) begin
         busy_in   = 1'b1;
         count_in  = CNT_W'(MULT_BITS);
         mcand_in  = mcand;
         mplier_in = mplier;
         acc_in    = init;
      end else if (busy_ff) begin
         acc_in    = acc_ff + (mplier_ff[0] ? mcand_ff : '0);
         mcand_in  = mcand_ff << 1;
         mplier_in = mplier_ff >> 1;
         count_in  = count_ff - 1'b1;
         if (count_ff == CNT_W'(1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         done_ff  <= 1'b0;
         count_ff <= '0;
      end else begin
         busy_ff  <= busy_in;
         done_ff  <= done_in;
         count_ff <= count_in;
      end
      mcand_ff  <= mcand_in;
      mplier_ff <= mplier_in;
      acc_ff    <= acc_in;
   end

   assign busy   = busy_ff;
   assign done   = done_ff;
   assign result = acc_ff;

endmodule
`default_nettype wire

/* hdl/angle_unwrap_speed_estimator_unit.sv */
`timescale 1ns / 1ps
`default_nettype none
// Channel  Direction  Handshake              Payload
// req      in         req_tvalid/req_tready  tdata: angle_raw; tuser: restart
// rsp      out        rsp_tvalid/rsp_tready  tdata: angle_total, speed
// csr      in         csr_we                 csr_index, csr_wdata
//
// A tracking sample runs through these steps before the next one is taken: the transfer cycle,
// which loads the first pass, 17 steps of delta * sample_rate in the shared shift-add unit,
// a cycle that loads the second pass, 17 steps of alpha * (speed - raw speed), a cycle that
// sees the pass finish and a saturation cycle that loads the output register and raises
// rsp_tvalid. A seeding sample goes from its transfer to S_SEED, which loads the output register.
// Reset is synchronous and clears the unwrap state and the registers to their defaults.
// The finished result sits in an output register; a stalled rsp holds the block
// in its last step until the transfer is taken.
module angle_unwrap_speed_estimator_unit #(
   parameter int ANGLE_BITS = aus_pkg::ANGLE_BITS_DEF,
   parameter int ACC_BITS   = aus_pkg::ACC_BITS_DEF
) (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              req_tvalid,
   output logic                                   req_tready,
   input  wire logic [aus_pkg::ANGLE_W-1:0]       req_tdata,  // [15:0] angle_raw
   input  wire logic                              req_tuser,  // [0] restart
   output logic                                   rsp_tvalid,
   input  wire logic                              rsp_tready,
   output logic [aus_pkg::RSP_DATA_W-1:0]         rsp_tdata,  // [31:0] angle_total, [63:32] speed
   input  wire logic                              csr_we,
   input  wire logic [aus_pkg::CSR_INDEX_W-1:0]   csr_index,
   input  wire logic [aus_pkg::CSR_DATA_W-1:0]    csr_wdata
);

   import aus_pkg::*;

   localparam int EXT_W   = (ANGLE_BITS > ANGLE_W) ? ANGLE_BITS : ANGLE_W;
   localparam int DIFF_W  = ANGLE_BITS + 2;
   localparam int DELTA_W = ANGLE_BITS + 1;
   localparam int RAW_W   = DELTA_W + RATE_W;
   localparam int DIF_W   = ((RAW_W > SPEED_W) ? RAW_W : SPEED_W) + 1;
   localparam int MAC_W   = DIF_W + ALPHA_W + 1;
   localparam int Q_W     = MAC_W - FRAC_BITS;

   localparam logic signed [DIFF_W-1:0] HALF_TURN     = DIFF_W'(2 ** (ANGLE_BITS - 1));
   localparam logic signed [DIFF_W-1:0] NEG_HALF_TURN = -HALF_TURN;
   localparam logic signed [DIFF_W-1:0] TURN          = DIFF_W'(2 ** ANGLE_BITS);
   localparam logic signed [Q_W-1:0]    Q_MAX         = Q_W'(S32_MAX);
   localparam logic signed [Q_W-1:0]    Q_MIN         = Q_W'(S32_MIN);

   typedef enum logic [2:0] {S_IDLE, S_RATE, S_ALPHA, S_SAT, S_SEED} state_type;

   state_type                     state_ff, state_in;
   logic [ALPHA_W-1:0]            alpha_ff, alpha_in;
   logic [RATE_W-1:0]             rate_ff, rate_in;
   logic [ANGLE_BITS-1:0]         prev_ff, prev_in;
   logic signed [ACC_BITS-1:0]    acc_ff, acc_in;
   logic signed [SPEED_W-1:0]     filt_ff, filt_in;
   logic                          seeded_ff, seeded_in;
   logic                          rsp_tvalid_ff, rsp_tvalid_in;
   logic [RSP_DATA_W-1:0]         rsp_data_ff, rsp_data_in;

   logic [EXT_W-1:0]              angle_ext;
   logic [ANGLE_BITS-1:0]         angle;
   logic                          restart, seeded_eff, req_accept, out_free;
   logic [ANGLE_BITS-1:0]         prev_eff;
   logic signed [ACC_BITS-1:0]    acc_eff;
   logic signed [DIFF_W-1:0]      diff, diff_adj;
   logic signed [DELTA_W-1:0]     delta;
   logic [ALPHA_W-1:0]            alpha_eff;
   logic signed [RAW_W-1:0]       raw_speed;
   logic signed [DIF_W-1:0]       speed_dif;
   logic signed [Q_W-1:0]         q;
   logic signed [SPEED_W-1:0]     speed_sat;

   logic                          mac_start, mac_busy, mac_done;
   logic [MAC_W-1:0]              mac_mcand, mac_init, mac_result;
   logic [ALPHA_W-1:0]            mac_mplier;

   assign req_accept = req_tvalid && req_tready;
   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign restart    = req_tuser;
   assign angle_ext  = EXT_W'(req_tdata);
   assign angle      = angle_ext[ANGLE_BITS-1:0];
   assign seeded_eff = seeded_ff && !restart;
   assign prev_eff   = restart ? '0 : prev_ff;
   assign acc_eff    = restart ? '0 : acc_ff;

   // unwrap into [-half turn, +half turn]
   assign diff = $signed({2'b00, angle}) - $signed({2'b00, prev_eff});
   always_comb begin
      priority if (diff > HALF_TURN) begin
         diff_adj = diff - TURN;
      end else if (diff < NEG_HALF_TURN) begin
         diff_adj = diff + TURN;
      end else begin
         diff_adj = diff;
      end
   end
   assign delta = diff_adj[DELTA_W-1:0];

   assign alpha_eff = (alpha_ff > ALPHA_ONE) ? ALPHA_ONE : alpha_ff;

   // filtered = raw + alpha * (filtered - raw), all over 2^16
   assign raw_speed = mac_result[RAW_W-1:0];
   assign speed_dif = DIF_W'(filt_ff) - DIF_W'(raw_speed);

   assign mac_start  = (state_ff == S_IDLE && req_accept && seeded_eff) ||
                       (state_ff == S_RATE && mac_done);
   assign mac_mcand  = (state_ff == S_IDLE) ? MAC_W'(delta) : MAC_W'(speed_dif);
   assign mac_mplier = (state_ff == S_IDLE) ? ALPHA_W'(rate_ff) : alpha_eff;
   assign mac_init   = (state_ff == S_IDLE) ? '0 : (MAC_W'(raw_speed) << FRAC_BITS);

   aus_serial_mac #(
      .WIDTH     (MAC_W),
      .MULT_BITS (ALPHA_W)
   ) u_mac (
      .clock  (clock),
      .reset  (reset),
      .start  (mac_start),
      .mcand  (mac_mcand),
      .mplier (mac_mplier),
      .init   (mac_init),
      .busy   (mac_busy),
      .done   (mac_done),
      .result (mac_result)
   );

   // floor shift, then clamp to 32 bits signed
   assign q = mac_result[MAC_W-1:FRAC_BITS];
   always_comb begin
      priority if (q > Q_MAX) begin
         speed_sat = SPEED_W'(S32_MAX);
      end else if (q < Q_MIN) begin
         speed_sat = SPEED_W'(S32_MIN);
      end else begin
         speed_sat = q[SPEED_W-1:0];
      end
   end

   always_comb begin
      state_in      = state_ff;
      alpha_in      = alpha_ff;
      rate_in       = rate_ff;
      prev_in       = prev_ff;
      acc_in        = acc_ff;
      filt_in       = filt_ff;
      seeded_in     = seeded_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      rsp_data_in   = rsp_data_ff;

      if (csr_we) begin
         unique case (csr_index)
            CSR_FILTER_ALPHA: alpha_in = csr_wdata[ALPHA_W-1:0];
            CSR_SAMPLE_RATE:  rate_in  = csr_wdata[RATE_W-1:0];
         endcase
      end

      unique case (state_ff)
         S_IDLE: begin
            if (req_accept) begin
               prev_in   = angle;
               seeded_in = 1'b1;
               filt_in   = restart ? '0 : filt_ff;
               if (seeded_eff) begin
                  acc_in   = acc_eff + ACC_BITS'(delta);
                  state_in = S_RATE;
               end else begin
                  acc_in   = acc_eff;
                  state_in = S_SEED;
               end
            end
         end
         S_RATE: begin
            if (mac_done) begin
               state_in = S_ALPHA;
            end
         end
         S_ALPHA: begin
            if (mac_done) begin
               state_in = S_SAT;
            end
         end
         S_SAT: begin
            // hold until the output register is free
            if (out_free) begin
               filt_in       = speed_sat;
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = {speed_sat, ANGLE_TOTAL_W'(acc_ff)};
               state_in      = S_IDLE;
            end
         end
         S_SEED: begin
            if (out_free) begin
               rsp_tvalid_in = 1'b1;
               rsp_data_in   = {{SPEED_W{1'b0}}, ANGLE_TOTAL_W'(acc_ff)};
               state_in      = S_IDLE;
            end
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         alpha_ff      <= ALPHA_RESET;
         rate_ff       <= RATE_RESET;
         prev_ff       <= '0;
         acc_ff        <= '0;
         filt_ff       <= '0;
         seeded_ff     <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         alpha_ff      <= alpha_in;
         rate_ff       <= rate_in;
         prev_ff       <= prev_in;
         acc_ff        <= acc_in;
         filt_ff       <= filt_in;
         seeded_ff     <= seeded_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
      rsp_data_ff <= rsp_data_in;
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;
   assign rsp_tdata  = rsp_data_ff;

   a_ready_mac_idle: assert property (@(posedge clock) disable iff (reset)
      req_tready |-> !mac_busy)
      else $error("input ready while the shift-add unit is busy");

   a_track_starts_mac: assert property (@(posedge clock) disable iff (reset)
      (req_accept && seeded_ff && !req_tuser) |=> (mac_busy && state_ff == S_RATE))
      else $error("tracking sample did not start the rate pass");

   a_seed_path: assert property (@(posedge clock) disable iff (reset)
      (req_accept && (!seeded_ff || req_tuser)) |=> (state_ff == S_SEED && !mac_busy))
      else $error("seeding sample did not take the seed path");

   a_alpha_pass_live: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_ALPHA) |-> (mac_busy || mac_done))
      else $error("alpha pass waiting on an idle shift-add unit");

endmodule
`default_nettype wire
